>>> rtl/refcounted_page_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame allocator
// Concurrent checks that compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// checked property, suspended while reset is high
`define RPFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define RPFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPFA_ASSERT(lbl, clk, rst, prop, msg)
`define RPFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/rpfa_pkg.sv
// ----------------------------------------------------------------------------
// rpfa_pkg
// Sizes, codes and shared types of the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rpfa_pkg;

   localparam int PAGE_COUNT = 1024;
   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = 8;
   localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int PAGE_W     = 10;
   localparam int CFG_W      = 11;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PAGE_W-1:0]     PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
   localparam logic [WORD_AW-1:0]    WORD_LAST = WORD_AW'(WORD_COUNT - 1);

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_SHARE = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NONE     = 2'd1,
      ST_RELEASED = 2'd2,
      ST_ERROR    = 2'd3
   } status_type;

   typedef struct packed {
      logic                 we;
      logic [WORD_AW-1:0]   waddr;
      logic [WORD_BITS-1:0] wdata;
      logic [WORD_AW-1:0]   raddr;
   } bm_req_type;

   typedef struct packed {
      logic                  we;
      logic [PAGE_W-1:0]     waddr;
      logic [COUNT_BITS-1:0] wdata;
      logic [PAGE_W-1:0]     raddr;
   } cnt_req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]     page;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } result_type;

   // index of the lowest set bit
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

>>> rtl/rpfa_bitmap_mem.sv
// ----------------------------------------------------------------------------
// rpfa_bitmap_mem
// Free bitmap, one word per entry, registered synchronous read.
// ----------------------------------------------------------------------------
`default_nettype none
module rpfa_bitmap_mem
   import rpfa_pkg::*;
(
   input  wire logic                 clock,
   input  wire bm_req_type           req,
   output logic [WORD_BITS-1:0]      rdata
);

   logic [WORD_BITS-1:0] words_ff [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         words_ff[req.waddr] <= req.wdata;
      end
      rdata_ff <= words_ff[req.raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/rpfa_count_mem.sv
// ----------------------------------------------------------------------------
// rpfa_count_mem
// Per-page reference counts, registered synchronous read.
// ----------------------------------------------------------------------------
`default_nettype none
module rpfa_count_mem
   import rpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire cnt_req_type           req,
   output logic [COUNT_BITS-1:0]      rdata
);

   logic [COUNT_BITS-1:0] counts_ff [PAGE_COUNT];
   logic [COUNT_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         counts_ff[req.waddr] <= req.wdata;
      end
      rdata_ff <= counts_ff[req.raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/rpfa_ctrl.sv
// ----------------------------------------------------------------------------
// rpfa_ctrl
// Command sequencer: clearing sweep, bitmap scan, count read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none
module rpfa_ctrl
   import rpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [PAGE_W-1:0]     req_page_in,
   input  wire logic [CFG_W-1:0]      reserved,
   output bm_req_type                 bm_req,
   input  wire logic [WORD_BITS-1:0]  bm_rdata,
   output cnt_req_type                cnt_req,
   input  wire logic [COUNT_BITS-1:0] cnt_rdata,
   output logic                       res_valid,
   output result_type                 res,
   input  wire logic                  out_free
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_RMW   = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic               init_ff, init_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic [WORD_AW-1:0] word_ff, word_in;
   cmd_type            cmd_ff, cmd_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   result_type         res_ff, res_in;

   logic [CFG_W-1:0]      res_sat, base, diff;
   logic [WORD_BITS-1:0]  init_word, bit_mask;
   logic [BIT_W-1:0]      hit;
   logic [PAGE_W-1:0]     hit_page;

   // free pattern of one bitmap word during the init sweep
   always_comb begin
      res_sat = (reserved > CFG_W'(PAGE_COUNT)) ? CFG_W'(PAGE_COUNT) : reserved;
      base    = CFG_W'(idx_ff[WORD_AW-1:0]) << BIT_W;
      diff    = res_sat - base;
      if (res_sat <= base) begin
         init_word = '1;
      end else if (diff >= CFG_W'(WORD_BITS)) begin
         init_word = '0;
      end else begin
         init_word = ~((WORD_BITS'(1) << diff[BIT_W-1:0]) - WORD_BITS'(1));
      end
   end

   assign hit      = first_set(bm_rdata);
   assign hit_page = {word_ff, hit};
   assign bit_mask = WORD_BITS'(1) << page_ff[BIT_W-1:0];

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      idx_in   = idx_ff;
      word_in  = word_ff;
      cmd_in   = cmd_ff;
      page_in  = page_ff;
      res_in   = res_ff;
      bm_req   = '0;
      cnt_req  = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cnt_req.we    = 1'b1;
            cnt_req.waddr = idx_ff;
            cnt_req.wdata = '0;
            if (idx_ff[PAGE_W-1:WORD_AW] == '0) begin
               bm_req.we    = 1'b1;
               bm_req.waddr = idx_ff[WORD_AW-1:0];
               bm_req.wdata = init_ff ? init_word : '0;
            end
            idx_in = idx_ff + PAGE_W'(1);
            if (idx_ff == PAGE_LAST) begin
               idx_in = '0;
               if (init_ff) begin
                  res_in   = '{page: '0, status: ST_OK, count: '0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = cmd_type'(req_cmd);
               page_in = req_page_in;
               unique case (cmd_type'(req_cmd))
                  CMD_INIT: begin
                     init_in  = 1'b1;
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_ALLOC: begin
                     bm_req.raddr = '0;
                     word_in      = '0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                     bm_req.raddr  = req_page_in[PAGE_W-1:BIT_W];
                     cnt_req.raddr = req_page_in;
                     state_in      = S_RMW;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (bm_rdata != '0) begin
               bm_req.we     = 1'b1;
               bm_req.waddr  = word_ff;
               bm_req.wdata  = bm_rdata & ~(WORD_BITS'(1) << hit);
               cnt_req.we    = 1'b1;
               cnt_req.waddr = hit_page;
               cnt_req.wdata = COUNT_BITS'(1);
               res_in   = '{page: hit_page, status: ST_OK, count: COUNT_BITS'(1)};
               state_in = S_RESP;
            end else if (word_ff == WORD_LAST) begin
               res_in   = '{page: '0, status: ST_NONE, count: '0};
               state_in = S_RESP;
            end else begin
               bm_req.raddr = word_ff + WORD_AW'(1);
               word_in      = word_ff + WORD_AW'(1);
            end
         end
         S_RMW: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_SHARE) begin
               if (cnt_rdata == COUNT_MAX) begin
                  res_in = '{page: page_ff, status: ST_ERROR, count: cnt_rdata};
               end else begin
                  cnt_req.we    = 1'b1;
                  cnt_req.waddr = page_ff;
                  cnt_req.wdata = cnt_rdata + COUNT_BITS'(1);
                  res_in = '{page: page_ff, status: ST_OK,
                             count: cnt_rdata + COUNT_BITS'(1)};
               end
            end else if (cnt_rdata == '0) begin
               res_in = '{page: page_ff, status: ST_ERROR, count: '0};
            end else begin
               cnt_req.we    = 1'b1;
               cnt_req.waddr = page_ff;
               cnt_req.wdata = cnt_rdata - COUNT_BITS'(1);
               if (cnt_rdata == COUNT_BITS'(1)) begin
                  bm_req.we    = 1'b1;
                  bm_req.waddr = page_ff[PAGE_W-1:BIT_W];
                  bm_req.wdata = bm_rdata | bit_mask;
                  res_in = '{page: page_ff, status: ST_RELEASED, count: '0};
               end else begin
                  res_in = '{page: page_ff, status: ST_OK,
                             count: cnt_rdata - COUNT_BITS'(1)};
               end
            end
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         init_ff  <= 1'b0;
         idx_ff   <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         idx_ff   <= idx_in;
         word_ff  <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      page_ff <= page_in;
      res_ff  <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res       = res_ff;

endmodule
`default_nettype wire

>>> rtl/refcounted_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// Bitmap page frame allocator with per-page reference counts.
//
// Request channel (req_valid/req_stall): one transfer carries a command and a
// page number. Result channel (rsp_valid/rsp_stall): one transfer per request.
// CSR channel (csr_valid/csr_ready): writes the reserved page count, ready always high.
// Steps per request, from transfer to result ready:
//   share, free : count and bitmap read, write back, result
//   allocate    : bitmap scan of n words, n = 1..32, one word
//                 a cycle through the bitmap read port, then result
//   init        : clearing sweep, one count entry written a cycle, then result
// One request is in work at a time; the next is accepted while the result
// register still waits, so rsp_stall only backs up once a second result
// is ready. After reset the block runs a clearing pass over the count
// memory and bitmap with req_stall high; no page is free until init.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_page_frame_allocator_assert.svh"
module refcounted_page_frame_allocator
   import rpfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [PAGE_W-1:0]     req_page_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [PAGE_W-1:0]          rsp_page_out,
   output logic [1:0]                 rsp_status,
   output logic [COUNT_BITS-1:0]      rsp_count_out,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CFG_W-1:0]      csr_data
);

   logic [CFG_W-1:0]      reserved_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   bm_req_type            bm_req;
   cnt_req_type           cnt_req;
   logic [WORD_BITS-1:0]  bm_rdata;
   logic [COUNT_BITS-1:0] cnt_rdata;
   logic                  res_valid;
   result_type            res;
   logic                  out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            reserved_ff <= csr_data;
         end
         if (out_free) begin
            rsp_valid_ff <= res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_ff <= res;
      end
   end

   rpfa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_page_in (req_page_in),
      .reserved    (reserved_ff),
      .bm_req      (bm_req),
      .bm_rdata    (bm_rdata),
      .cnt_req     (cnt_req),
      .cnt_rdata   (cnt_rdata),
      .res_valid   (res_valid),
      .res         (res),
      .out_free    (out_free)
   );

   rpfa_bitmap_mem u_bitmap (
      .clock (clock),
      .req   (bm_req),
      .rdata (bm_rdata)
   );

   rpfa_count_mem u_counts (
      .clock (clock),
      .req   (cnt_req),
      .rdata (cnt_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_page_out  = rsp_ff.page;
   assign rsp_status    = rsp_ff.status;
   assign rsp_count_out = rsp_ff.count;

   `RPFA_ASSERT(a_one_in_work, clock, reset, (req_valid && !req_stall) |=> req_stall, "request accepted while busy")
   `RPFA_ASSERT(a_none_clean, clock, reset, (rsp_valid && rsp_status == ST_NONE) |-> (rsp_page_out == '0 && rsp_count_out == '0), "no-free result not zeroed")
   `RPFA_ASSERT(a_release_zero, clock, reset, (rsp_valid && rsp_status == ST_RELEASED) |-> (rsp_count_out == '0), "released page with nonzero count")
   `RPFA_ASSERT_ALWAYS(a_reset_busy, clock, $past(reset) |-> (req_stall && !rsp_valid), "accepting during clearing pass")

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives init, allocate, share and free requests through the request channel
// and checks every result against a bitmap and reference-count predictor.
// A directed table covers reset state, saturated reservation, free-page share,
// release, underflow and empty pool. Random phases follow with different
// reservation settings, sender gaps, receiver stalls, a long receiver hold-off
// and one count pumped past its maximum.
// ----------------------------------------------------------------------------
module tb;
   import rpfa_pkg::*;

   localparam int QUIET_LIMIT = 8000;
   localparam int HOLD_LEN    = 300;
   localparam int DIR_N       = 19;
   localparam int PHASE_N     = 5;
   localparam int PUMP_N      = 262;

   typedef struct packed {
      cmd_type           cmd;
      logic [PAGE_W-1:0] page;
      logic              from_table;
      result_type        want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cmd = CMD_INIT;
   logic [PAGE_W-1:0]     req_page_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PAGE_W-1:0]     rsp_page_out;
   logic [1:0]            rsp_status;
   logic [COUNT_BITS-1:0] rsp_count_out;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;

   // predictor state
   logic [PAGE_COUNT-1:0] pool_free;
   logic [COUNT_BITS-1:0] page_refs [PAGE_COUNT];
   logic [CFG_W-1:0]      reserved_cfg;

   result_type  awaited_results [$];
   dir_row_type dir_rows [DIR_N];
   int          err_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   refcounted_page_frame_allocator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_page_in   (req_page_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_page_out  (rsp_page_out),
      .rsp_status    (rsp_status),
      .rsp_count_out (rsp_count_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   function automatic result_type predict_page_op(input cmd_type c,
                                                  input logic [PAGE_W-1:0] p);
      result_type r;
      int         held;
      logic [COUNT_BITS-1:0] cnt;
      r.page   = p;
      r.status = ST_OK;
      r.count  = '0;
      case (c)
         CMD_INIT: begin
            held = (reserved_cfg > PAGE_COUNT) ? PAGE_COUNT : int'(reserved_cfg);
            for (int i = 0; i < PAGE_COUNT; i++) begin
               pool_free[i] = (i >= held);
               page_refs[i] = '0;
            end
            r.page = '0;
         end
         CMD_ALLOC: begin
            r.page   = '0;
            r.status = ST_NONE;
            for (int i = 0; i < PAGE_COUNT; i++) begin
               if (pool_free[i] && r.status == ST_NONE) begin
                  pool_free[i] = 1'b0;
                  page_refs[i] = COUNT_BITS'(1);
                  r.page       = PAGE_W'(i);
                  r.status     = ST_OK;
                  r.count      = COUNT_BITS'(1);
               end
            end
         end
         CMD_SHARE: begin
            cnt = page_refs[p];
            if (cnt == COUNT_MAX) begin
               r.status = ST_ERROR;
               r.count  = cnt;
            end else begin
               page_refs[p] = cnt + 1'b1;
               r.count      = cnt + 1'b1;
            end
         end
         default: begin
            cnt = page_refs[p];
            if (cnt == 0) begin
               r.status = ST_ERROR;
            end else begin
               cnt          = cnt - 1'b1;
               page_refs[p] = cnt;
               r.count      = cnt;
               if (cnt == 0) begin
                  pool_free[p] = 1'b1;
                  r.status     = ST_RELEASED;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [PAGE_W-1:0] pick_live_page();
      logic [PAGE_W-1:0] live [$];
      for (int i = 0; i < PAGE_COUNT; i++) begin
         if (page_refs[i] != 0) begin
            live.push_back(PAGE_W'(i));
         end
      end
      if (live.size() == 0) begin
         return PAGE_W'($urandom);
      end
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   task automatic send_req(input cmd_type c, input logic [PAGE_W-1:0] p,
                           input logic from_table, input result_type want);
      result_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_page_in <= p;
      do @(posedge clock); while (req_stall);
      got = predict_page_op(c, p);
      awaited_results.push_back(from_table ? want : got);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reserved(input logic [CFG_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      reserved_cfg  = v;
   endtask

   task automatic run_mix(input int budget);
      int sent;
      int kind;
      int len;
      logic [PAGE_W-1:0] pg;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 99);
         if (kind < 2) begin
            send_req(CMD_INIT, PAGE_W'($urandom), 1'b0, '0);
            sent++;
         end else if (kind < 40) begin
            len = $urandom_range(1, 8);
            repeat (len) send_req(CMD_ALLOC, PAGE_W'($urandom), 1'b0, '0);
            sent += len;
         end else if (kind < 62) begin
            send_req(CMD_SHARE, pick_live_page(), 1'b0, '0);
            sent++;
         end else if (kind < 88) begin
            send_req(CMD_FREE, pick_live_page(), 1'b0, '0);
            sent++;
         end else if (kind < 95) begin
            send_req(cmd_type'($urandom_range(CMD_SHARE, CMD_FREE)), PAGE_W'($urandom),
                     1'b0, '0);
            sent++;
         end else begin
            pg  = pick_live_page();
            len = $urandom_range(1, 12);
            repeat (len) send_req(CMD_SHARE, pg, 1'b0, '0);
            repeat (len + 1) send_req(CMD_FREE, pg, 1'b0, '0);
            sent += 2 * len + 1;
         end
      end
   endtask

   // receiver: stalls, hold-off and result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result page %0d status %0d count %0d",
                     $time, rsp_page_out, rsp_status, rsp_count_out);
            err_count++;
         end else begin
            if (rsp_page_out !== awaited_results[0].page) begin
               $display("%0t: page_out expected %0d, actual %0d", $time,
                        awaited_results[0].page, rsp_page_out);
               err_count++;
            end
            if (rsp_status !== awaited_results[0].status) begin
               $display("%0t: status expected %0d, actual %0d", $time,
                        awaited_results[0].status, rsp_status);
               err_count++;
            end
            if (rsp_count_out !== awaited_results[0].count) begin
               $display("%0t: count_out expected %0d, actual %0d", $time,
                        awaited_results[0].count, rsp_count_out);
               err_count++;
            end
            void'(awaited_results.pop_front());
         end
      end
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                phase_send [PHASE_N];
      int                phase_stall [PHASE_N];
      int                phase_items [PHASE_N];
      logic [CFG_W-1:0]  phase_reserved [PHASE_N];
      logic [PAGE_W-1:0] pg;

      phase_send     = '{0, 75, 0, 14, 0};
      phase_stall    = '{0, 0, 75, 14, 0};
      phase_items    = '{400, 300, 350, 250, 330};
      phase_reserved = '{11'd0, 11'd1000, CFG_W'($urandom_range(1, 1023)), 11'd1024,
                         CFG_W'($urandom_range(1, 64))};

      dir_rows = '{
         '{CMD_ALLOC, 10'd0,   1'b1, '{10'd0,   ST_NONE,     8'd0}},
         '{CMD_INIT,  10'h3FF, 1'b1, '{10'd0,   ST_OK,       8'd0}},
         '{CMD_ALLOC, 10'h3FF, 1'b1, '{10'd0,   ST_NONE,     8'd0}},
         '{CMD_SHARE, 10'd1023, 1'b1, '{10'd1023, ST_OK,     8'd1}},
         '{CMD_FREE,  10'd1023, 1'b1, '{10'd1023, ST_RELEASED, 8'd0}},
         '{CMD_SHARE, 10'd1023, 1'b0, '0},
         '{CMD_ALLOC, 10'd0,   1'b0, '0},
         '{CMD_ALLOC, 10'd0,   1'b1, '{10'd0,   ST_NONE,     8'd0}},
         '{CMD_FREE,  10'd1023, 1'b1, '{10'd1023, ST_RELEASED, 8'd0}},
         '{CMD_FREE,  10'd1023, 1'b1, '{10'd1023, ST_ERROR,  8'd0}},
         '{CMD_SHARE, 10'd0,   1'b0, '0},
         '{CMD_SHARE, 10'd0,   1'b0, '0},
         '{CMD_FREE,  10'd0,   1'b0, '0},
         '{CMD_FREE,  10'd0,   1'b0, '0},
         '{CMD_SHARE, 10'd682, 1'b0, '0},
         '{CMD_FREE,  10'd341, 1'b1, '{10'd341, ST_ERROR,    8'd0}},
         '{CMD_FREE,  10'd682, 1'b0, '0},
         '{CMD_ALLOC, 10'd0,   1'b0, '0},
         '{CMD_ALLOC, 10'd0,   1'b0, '0}
      };

      pool_free    = '0;
      reserved_cfg = '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         page_refs[i] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table with every page reserved (saturated setting)
      write_reserved(11'd2047);
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].cmd, dir_rows[i].page, dir_rows[i].from_table,
                  dir_rows[i].want);
      end

      for (int ph = 0; ph < PHASE_N; ph++) begin
         wait_all_results();
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         write_reserved(phase_reserved[ph]);
         send_req(CMD_INIT, PAGE_W'($urandom), 1'b0, '0);
         if (ph == 0) begin
            // pump one count past its maximum
            send_req(CMD_ALLOC, '0, 1'b0, '0);
            pg = pick_live_page();
            repeat (258) send_req(CMD_SHARE, pg, 1'b0, '0);
            repeat (3) send_req(CMD_FREE, pg, 1'b0, '0);
            run_mix((phase_items[ph] - PUMP_N) / 2);
            hold_token++;
            run_mix((phase_items[ph] - PUMP_N) / 2);
         end else begin
            run_mix(phase_items[ph]);
         end
      end

      wait_all_results();
      repeat (40) @(posedge clock);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/rpfa_pkg.sv
rtl/rpfa_bitmap_mem.sv
rtl/rpfa_count_mem.sv
rtl/rpfa_ctrl.sv
rtl/refcounted_page_frame_allocator.sv
test/tb.sv
